>>> rtl/small_matrix_arithmetic_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for small_matrix_arithmetic
// Shorthand for the concurrent checks that the checker module binds in.
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_ARITHMETIC_ASSERT_SVH
`define SMALL_MATRIX_ARITHMETIC_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define SMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("small_matrix_arithmetic: check failed");

// next-cycle implication, off while reset is asserted
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("small_matrix_arithmetic: check failed");

// same-cycle implication that also holds during reset
`define SMA_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("small_matrix_arithmetic: check failed");

`endif

>>> rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Field widths, codes, controller states and the control/status structs of
// the small matrix arithmetic block.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int ACTION_W   = 2;
    localparam int POS_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int DIM_REG_W  = 4;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int FRAC_W     = 16;

    localparam logic [ACTION_W-1:0] ACT_WRITE_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_READ,
        ST_OPER,
        ST_ACC,
        ST_ROUND,
        ST_EMIT
    } sma_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic load_sum;
        logic load_prod;
        logic acc_clr;
        logic acc_add;
        logic load_round;
        logic out_load;
        logic out_err;
        logic out_last;
    } sma_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic is_compute;
        logic mismatch;
        logic op_mul;
        logic t_end;
        logic j_end;
        logic i_end;
        logic res_free;
    } sma_stat_t;

endpackage

>>> rtl/sma_channels.sv
// ----------------------------------------------------------------------------
// sma channels
// Valid/ready channels of the block: command beats, result beats and
// configuration register writes.
// ----------------------------------------------------------------------------
interface sma_cmd_if;
    import sma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           column;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, action, row, column, value, input ready);
    modport sink (input valid, action, row, column, value, output ready);
endinterface

interface sma_res_if;
    import sma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [POS_W-1:0]           out_row;
    logic [POS_W-1:0]           out_column;
    logic signed [VALUE_W-1:0]  out_value;
    logic                       last;
    logic                       error;

    modport source (output valid, out_row, out_column, out_value, last, error, input ready);
    modport sink (input valid, out_row, out_column, out_value, last, error, output ready);
endinterface

interface sma_cfg_if;
    import sma_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/sma_dpath.sv
// ----------------------------------------------------------------------------
// sma_dpath
// Datapath: configuration registers, the two element stores, the
// multiply-accumulate unit, rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module sma_dpath #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [sma_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sma_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [sma_pkg::ACTION_W-1:0]        action,
    input  logic [sma_pkg::POS_W-1:0]           row,
    input  logic [sma_pkg::POS_W-1:0]           column,
    input  logic signed [sma_pkg::VALUE_W-1:0]  value,
    input  logic [$clog2(MAX_DIM)-1:0]          i_idx,
    input  logic [$clog2(MAX_DIM)-1:0]          j_idx,
    input  logic [$clog2(MAX_DIM)-1:0]          t_idx,
    input  sma_pkg::sma_ctrl_t                  ctrl,
    output sma_pkg::sma_stat_t                  stat,
    input  logic                                res_ready,
    output logic                                res_valid,
    output logic [sma_pkg::POS_W-1:0]           res_row,
    output logic [sma_pkg::POS_W-1:0]           res_column,
    output logic signed [sma_pkg::VALUE_W-1:0]  res_value,
    output logic                                res_last,
    output logic                                res_error
);
    import sma_pkg::*;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (DIM_W > POS_W) ? DIM_W : POS_W;
    localparam int PROD_W = 2 * VALUE_W;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int PRE_W  = ACC_W - FRAC_W;
    localparam int SAT_W  = (DATA_WIDTH > VALUE_W) ? VALUE_W : DATA_WIDTH;

    localparam logic signed [PRE_W-1:0] SAT_HI =
        PRE_W'((longint'(1) <<< (SAT_W - 1)) - longint'(1));
    localparam logic signed [PRE_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(longint'(1) <<< (FRAC_W - 1));

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0)
        begin
            d = DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            d = DIM_W'(MAX_DIM);
        end
        else
        begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    logic [DIM_REG_W-1:0]       a_rows_reg;
    logic [DIM_REG_W-1:0]       a_cols_reg;
    logic [DIM_REG_W-1:0]       b_rows_reg;
    logic [DIM_REG_W-1:0]       b_cols_reg;
    logic [OP_W-1:0]            op_reg;

    logic [DIM_W-1:0]           ar;
    logic [DIM_W-1:0]           ac;
    logic [DIM_W-1:0]           br;
    logic [DIM_W-1:0]           bc;
    logic [DIM_W-1:0]           rc;
    logic                       mismatch;
    logic                       op_mul;

    logic [DIM_W-1:0]           wr_rows;
    logic [DIM_W-1:0]           wr_cols;
    logic                       wr_in_range;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       wr_a_en;
    logic                       wr_b_en;

    logic [IDX_W-1:0]           a_col_sel;
    logic [IDX_W-1:0]           b_row_sel;
    logic [ADDR_W-1:0]          rd_addr_a;
    logic [ADDR_W-1:0]          rd_addr_b;

    logic [VALUE_W-1:0]         mem_a [DEPTH];
    logic [VALUE_W-1:0]         mem_b [DEPTH];
    logic signed [VALUE_W-1:0]  rd_a_reg;
    logic signed [VALUE_W-1:0]  rd_b_reg;

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PRE_W-1:0]    pre_reg;
    logic signed [PRE_W-1:0]    sat_val;

    logic                       res_valid_reg;
    logic                       res_valid_next;
    logic [POS_W-1:0]           res_row_reg;
    logic [POS_W-1:0]           res_column_reg;
    logic signed [VALUE_W-1:0]  res_value_reg;
    logic                       res_last_reg;
    logic                       res_error_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_REG_W'(1);
            a_cols_reg <= DIM_REG_W'(1);
            b_rows_reg <= DIM_REG_W'(1);
            b_cols_reg <= DIM_REG_W'(1);
            op_reg     <= OP_ADD;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_A_ROWS:    a_rows_reg <= cfg_data;
                CFG_A_COLS:    a_cols_reg <= cfg_data;
                CFG_B_ROWS:    b_rows_reg <= cfg_data;
                CFG_B_COLS:    b_cols_reg <= cfg_data;
                CFG_OPERATION: op_reg     <= cfg_data[OP_W-1:0];
                default:       ;
            endcase
        end
    end

    assign ar     = clamp_dim(a_rows_reg);
    assign ac     = clamp_dim(a_cols_reg);
    assign br     = clamp_dim(b_rows_reg);
    assign bc     = clamp_dim(b_cols_reg);
    assign op_mul = (op_reg == OP_MUL);
    assign rc     = op_mul ? bc : ac;

    always_comb
    begin
        case (op_reg)
            OP_ADD, OP_SUB: mismatch = (ar != br) || (ac != bc);
            OP_MUL:         mismatch = (ac != br);
            default:        mismatch = 1'b1;
        endcase
    end

    assign stat.is_compute = (action == ACT_COMPUTE);
    assign stat.mismatch   = mismatch;
    assign stat.op_mul     = op_mul;
    assign stat.t_end      = (DIM_W'(t_idx) + DIM_W'(1)) == ac;
    assign stat.j_end      = (DIM_W'(j_idx) + DIM_W'(1)) == rc;
    assign stat.i_end      = (DIM_W'(i_idx) + DIM_W'(1)) == ar;
    assign stat.res_free   = !res_valid_reg || res_ready;

    // element write: drop beats outside the configured shape
    assign wr_rows     = (action == ACT_WRITE_B) ? br : ar;
    assign wr_cols     = (action == ACT_WRITE_B) ? bc : ac;
    assign wr_in_range = (CMP_W'(row) < CMP_W'(wr_rows)) && (CMP_W'(column) < CMP_W'(wr_cols));
    assign wr_addr     = ADDR_W'(wr_cols) * ADDR_W'(row) + ADDR_W'(column);
    assign wr_a_en     = ctrl.accept && (action == ACT_WRITE_A) && wr_in_range;
    assign wr_b_en     = ctrl.accept && (action == ACT_WRITE_B) && wr_in_range;

    // multiply walks A(i,t) and B(t,j); add/subtract reads A(i,j) and B(i,j)
    assign a_col_sel = op_mul ? t_idx : j_idx;
    assign b_row_sel = op_mul ? t_idx : i_idx;
    assign rd_addr_a = ADDR_W'(ac) * ADDR_W'(i_idx) + ADDR_W'(a_col_sel);
    assign rd_addr_b = ADDR_W'(bc) * ADDR_W'(b_row_sel) + ADDR_W'(j_idx);

    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            mem_a[wr_addr] <= value;
        end
        if (ctrl.rd_en)
        begin
            rd_a_reg <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_b_en)
        begin
            mem_b[wr_addr] <= value;
        end
        if (ctrl.rd_en)
        begin
            rd_b_reg <= mem_b[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_reg <= rd_a_reg * rd_b_reg;
        end
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.load_sum)
        begin
            pre_reg <= (op_reg == OP_SUB) ? PRE_W'(rd_a_reg) - PRE_W'(rd_b_reg)
                                          : PRE_W'(rd_a_reg) + PRE_W'(rd_b_reg);
        end
        else if (ctrl.load_round)
        begin
            // round to nearest, halves toward plus infinity
            pre_reg <= PRE_W'((acc_reg + HALF_LSB) >>> FRAC_W);
        end
    end

    always_comb
    begin
        if (pre_reg > SAT_HI)
        begin
            sat_val = SAT_HI;
        end
        else if (pre_reg < SAT_LO)
        begin
            sat_val = SAT_LO;
        end
        else
        begin
            sat_val = pre_reg;
        end
    end

    // result register: holds a beat until the sink takes it
    always_comb
    begin
        if (ctrl.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            res_row_reg    <= ctrl.out_err ? '0 : POS_W'(i_idx);
            res_column_reg <= ctrl.out_err ? '0 : POS_W'(j_idx);
            res_value_reg  <= ctrl.out_err ? '0 : VALUE_W'(sat_val);
            res_last_reg   <= ctrl.out_last;
            res_error_reg  <= ctrl.out_err;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_row    = res_row_reg;
    assign res_column = res_column_reg;
    assign res_value  = res_value_reg;
    assign res_last   = res_last_reg;
    assign res_error  = res_error_reg;

endmodule

>>> rtl/sma_ctrl.sv
// ----------------------------------------------------------------------------
// sma_ctrl
// Controller: takes command beats, and for a compute walks rows, columns and
// the dot-product index, sequencing the datapath one step per state.
// ----------------------------------------------------------------------------
module sma_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  sma_pkg::sma_stat_t          stat,
    output sma_pkg::sma_ctrl_t          ctrl,
    output logic [$clog2(MAX_DIM)-1:0]  i_idx,
    output logic [$clog2(MAX_DIM)-1:0]  j_idx,
    output logic [$clog2(MAX_DIM)-1:0]  t_idx
);
    import sma_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIM);

    sma_state_t         state_reg;
    sma_state_t         state_next;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   i_next;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   j_next;
    logic [IDX_W-1:0]   t_reg;
    logic [IDX_W-1:0]   t_next;
    logic               start;
    logic               final_elem;

    assign start      = (state_reg == ST_IDLE) && cmd_valid && stat.is_compute;
    assign final_elem = stat.i_end && stat.j_end;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = stat.mismatch ? ST_ERR : ST_READ;
                end
            end
            ST_ERR:
            begin
                if (stat.res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:  state_next = ST_OPER;
            ST_OPER:  state_next = stat.op_mul ? ST_ACC : ST_EMIT;
            ST_ACC:   state_next = stat.t_end ? ST_ROUND : ST_READ;
            ST_ROUND: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (stat.res_free)
                begin
                    state_next = final_elem ? ST_IDLE : ST_READ;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready    = 1'b1;
                ctrl.accept  = cmd_valid;
                ctrl.acc_clr = start;
            end
            ST_ERR:
            begin
                ctrl.out_load = stat.res_free;
                ctrl.out_err  = 1'b1;
                ctrl.out_last = 1'b1;
            end
            ST_READ:  ctrl.rd_en = 1'b1;
            ST_OPER:
            begin
                ctrl.load_prod = stat.op_mul;
                ctrl.load_sum  = !stat.op_mul;
            end
            ST_ACC:   ctrl.acc_add = 1'b1;
            ST_ROUND: ctrl.load_round = 1'b1;
            ST_EMIT:
            begin
                ctrl.out_load = stat.res_free;
                ctrl.out_last = final_elem;
                ctrl.acc_clr  = stat.res_free;
            end
            default:  ;
        endcase
    end

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        t_next = t_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    i_next = '0;
                    j_next = '0;
                    t_next = '0;
                end
            end
            ST_ACC:
            begin
                if (!stat.t_end)
                begin
                    t_next = t_reg + IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                // advance row-major to the next element
                if (stat.res_free && !final_elem)
                begin
                    t_next = '0;
                    if (stat.j_end)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            t_reg     <= t_next;
        end
    end

    assign i_idx = i_reg;
    assign j_idx = j_reg;
    assign t_idx = t_reg;

endmodule

>>> rtl/small_matrix_arithmetic.sv
// ----------------------------------------------------------------------------
// small_matrix_arithmetic
// Add, subtract or multiply two stored Q16.16 matrices of up to MAX_DIM square.
// cmd beats: action write A / write B store one element at (row, column) and are
//   taken one per cycle while idle; writes outside the configured shape are dropped.
// A compute beat streams the result row-major on result, last on the final
// beat; a shape mismatch or undefined operation gives one error beat instead.
// cfg writes a_rows, a_cols, b_rows, b_cols, operation; ready is always high.
// After a compute is accepted the error beat goes out once the result register is
//   free. Add/subtract: read, add, emit per element. Multiply: read, multiply,
//   accumulate per a_cols term on the single store read port, then round, emit.
// cmd.ready is low while a compute runs; the final beat may still wait in the
// result register while the next commands are taken.
// A stalled result holds the walk until the sink takes the beat.
// Reset: dimensions 1, operation add, no beat pending; stores are undefined
// until written.
// ----------------------------------------------------------------------------
module small_matrix_arithmetic #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sma_cmd_if.sink     cmd,
    sma_res_if.source   result,
    sma_cfg_if.sink     cfg
);
    import sma_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIM);

    sma_ctrl_t          ctrl;
    sma_stat_t          stat;
    logic [IDX_W-1:0]   i_idx;
    logic [IDX_W-1:0]   j_idx;
    logic [IDX_W-1:0]   t_idx;
    logic               cmd_ready;

    assign cmd.ready = cmd_ready;
    assign cfg.ready = 1'b1;

    sma_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctrl      (ctrl),
        .i_idx     (i_idx),
        .j_idx     (j_idx),
        .t_idx     (t_idx)
    );

    sma_dpath #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .action     (cmd.action),
        .row        (cmd.row),
        .column     (cmd.column),
        .value      (cmd.value),
        .i_idx      (i_idx),
        .j_idx      (j_idx),
        .t_idx      (t_idx),
        .ctrl       (ctrl),
        .stat       (stat),
        .res_ready  (result.ready),
        .res_valid  (result.valid),
        .res_row    (result.out_row),
        .res_column (result.out_column),
        .res_value  (result.out_value),
        .res_last   (result.last),
        .res_error  (result.error)
    );

endmodule

>>> rtl/sma_checker.sv
// ----------------------------------------------------------------------------
// sma_checker
// Port-level checks of small_matrix_arithmetic, bound to the top level.
// ----------------------------------------------------------------------------
`include "small_matrix_arithmetic_assert.svh"

module sma_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cmd_valid,
    input logic                                 cmd_ready,
    input logic [sma_pkg::ACTION_W-1:0]         cmd_action,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input logic [sma_pkg::POS_W-1:0]            res_row,
    input logic [sma_pkg::POS_W-1:0]            res_column,
    input logic signed [sma_pkg::VALUE_W-1:0]   res_value,
    input logic                                 res_last,
    input logic                                 res_error
);
    import sma_pkg::*;

    // a stalled result beat holds
    `SMA_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_row) && $stable(res_column) && $stable(res_last) && $stable(res_error))

    // an error beat is the only beat of its compute and carries zeros
    `SMA_ASSERT_SAME(a_err_shape, clk, rst_n, res_valid && res_error, res_last && res_value == '0 && res_row == '0 && res_column == '0)

    // a compute blocks further commands until its walk is done
    `SMA_ASSERT_NEXT(a_busy_after_compute, clk, rst_n, cmd_valid && cmd_ready && cmd_action == ACT_COMPUTE, !cmd_ready)

    // no result beat shows during reset
    `SMA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !res_valid)

endmodule

bind small_matrix_arithmetic sma_checker u_sma_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_action (cmd.action),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_row    (result.out_row),
    .res_column (result.out_column),
    .res_value  (result.out_value),
    .res_last   (result.last),
    .res_error  (result.error)
);
